@@ hdl/cv_two_point_calibration_top_macros.svh @@
// Assertion macros used by the calibrator controller.
`ifndef CV_TWO_POINT_CALIBRATION_TOP_MACROS_SVH
`define CV_TWO_POINT_CALIBRATION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define CVC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define CVC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/cvc_pkg.sv @@
// Types, constants and codes of the two-point calibrator.
package cvc_pkg;

	typedef enum logic [1:0] {
		OP_CONV_IN   = 2'd0,
		OP_CONV_OUT  = 2'd1,
		OP_TRIM_ZERO = 2'd2,
		OP_TRIM_FOUR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_LOAD,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	localparam logic [1:0] CFG_CH1_IN_ZERO = 2'd0;
	localparam logic [1:0] CFG_CH1_IN_FOUR = 2'd1;
	localparam logic [1:0] CFG_CH2_IN_ZERO = 2'd2;
	localparam logic [1:0] CFG_CH2_IN_FOUR = 2'd3;

	localparam int DVD_W     = 23;
	localparam int DVS_W     = 10;
	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W     = 5;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	localparam logic signed [12:0] SPAN_MV   = 13'sd4000;
	// (four - zero) * 65536 / 4000 equals (four - zero) * 2048 / 125.
	localparam logic [DVS_W-1:0]   SLOPE_DVS = 10'd125;
	localparam int                 SLOPE_SHIFT = 11;
	localparam logic [11:0]        CODE_MAX  = 12'd4095;

	localparam logic [9:0]  IN_ZERO_RST0  = 10'd571;
	localparam logic [9:0]  IN_FOUR_RST0  = 10'd269;
	localparam logic [9:0]  IN_ZERO_RST1  = 10'd573;
	localparam logic [9:0]  IN_FOUR_RST1  = 10'd270;
	localparam logic [11:0] OUT_ZERO_RST0 = 12'd1335;
	localparam logic [11:0] OUT_ZERO_RST1 = 12'd1328;
	localparam logic [11:0] OUT_FOUR_RST0 = 12'd2659;
	localparam logic [11:0] OUT_FOUR_RST1 = 12'd2653;
	localparam logic [16:0] SLOPE_RST0    = 17'd21692;
	localparam logic [16:0] SLOPE_RST1    = 17'd21708;

	typedef struct packed {
		logic load_req;
		logic prep;
		logic load;
		logic div_step;
		logic fin;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic den_zero;
		logic out_free;
	} dp_stat_t;

endpackage

@@ hdl/cvc_if.sv @@
// Request and result channel interfaces of the calibrator.
interface cvc_req_if;
	logic               valid;
	logic               ready;
	cvc_pkg::op_t       op;
	logic               channel;
	logic [9:0]         raw_sample;
	logic signed [15:0] millivolts;
	logic signed [15:0] trim_delta;

	modport source (output valid, op, channel, raw_sample, millivolts, trim_delta,
		input ready);
	modport sink (input valid, op, channel, raw_sample, millivolts, trim_delta,
		output ready);
endinterface

interface cvc_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] cv_in_mv;
	logic [11:0]        dac_code;
	logic [11:0]        point_value;
	cvc_pkg::status_t   status;

	modport source (output valid, cv_in_mv, dac_code, point_value, status, input ready);
	modport sink (input valid, cv_in_mv, dac_code, point_value, status, output ready);
endinterface

@@ hdl/cvc_ctrl.sv @@
// Sequencing state machine of the calibrator.
`include "cv_two_point_calibration_top_macros.svh"

module cvc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  cvc_pkg::dp_stat_t    stat,
	output cvc_pkg::ctrl_cmd_t   cmd
);

	cvc_pkg::state_t state_q, state_d;
	logic [cvc_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cvc_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cvc_pkg::S_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == cvc_pkg::S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cvc_pkg::S_IDLE: begin
				if (req_valid) state_d = cvc_pkg::S_PREP;
			end
			cvc_pkg::S_PREP: state_d = cvc_pkg::S_LOAD;
			cvc_pkg::S_LOAD: begin
				// Output conversion and a zero input span finish without the divider.
				if (stat.op == cvc_pkg::OP_CONV_OUT ||
				    (stat.op == cvc_pkg::OP_CONV_IN && stat.den_zero)) begin
					state_d = cvc_pkg::S_OUT;
				end else begin
					state_d = cvc_pkg::S_DIV;
				end
			end
			cvc_pkg::S_DIV: begin
				if (cnt_q == cvc_pkg::DIV_LAST) state_d = cvc_pkg::S_FIN;
			end
			cvc_pkg::S_FIN: state_d = cvc_pkg::S_OUT;
			cvc_pkg::S_OUT: begin
				if (stat.out_free) state_d = cvc_pkg::S_IDLE;
			end
			default: state_d = cvc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = (state_q == cvc_pkg::S_IDLE);
		cmd.load_req = (state_q == cvc_pkg::S_IDLE) && req_valid;
		cmd.prep     = (state_q == cvc_pkg::S_PREP);
		cmd.load     = (state_q == cvc_pkg::S_LOAD);
		cmd.div_step = (state_q == cvc_pkg::S_DIV);
		cmd.fin      = (state_q == cvc_pkg::S_FIN);
		cmd.out_load = (state_q == cvc_pkg::S_OUT) && stat.out_free;
	end

	`CVC_ASSERT_NXT(a_accept_prep, cmd.load_req, state_q == cvc_pkg::S_PREP, "accepted request did not start preparation")
	`CVC_ASSERT_NXT(a_div_done, (state_q == cvc_pkg::S_DIV) && (cnt_q == cvc_pkg::DIV_LAST), state_q == cvc_pkg::S_FIN, "divider did not finish after its last step")
	`CVC_ASSERT_IMP(a_cnt_range, state_q == cvc_pkg::S_DIV, cnt_q <= cvc_pkg::DIV_LAST, "divider step count overran")
	`CVC_ASSERT_NXT(a_out_idle, cmd.out_load, state_q == cvc_pkg::S_IDLE, "controller did not return to idle after result load")

endmodule

@@ hdl/cvc_datapath.sv @@
// Calibration state, operand logic, shared divider and result register.
module cvc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  cvc_pkg::ctrl_cmd_t cmd,
	output cvc_pkg::dp_stat_t  stat,
	input  cvc_pkg::op_t       op,
	input  logic               channel,
	input  logic [9:0]         raw_sample,
	input  logic signed [15:0] millivolts,
	input  logic signed [15:0] trim_delta,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data,
	cvc_rsp_if.source          rsp
);

	// Configuration and calibration state per channel.
	logic [9:0]  in_zero_q  [2];
	logic [9:0]  in_four_q  [2];
	logic [11:0] out_zero_q [2];
	logic [11:0] out_four_q [2];
	logic [16:0] slope_q    [2];

	// Request held for the duration of the operation.
	cvc_pkg::op_t       op_q;
	logic               ch_q;
	logic [9:0]         raw_q;
	logic signed [15:0] mv_q;
	logic signed [15:0] delta_q;

	logic signed [10:0] ndiff_q;
	logic signed [10:0] den_q;
	logic signed [33:0] prod_q;
	logic [11:0]        point_q;

	logic [cvc_pkg::DVD_W-1:0] dvd_q;
	logic [cvc_pkg::DVS_W-1:0] rem_q;
	logic [cvc_pkg::DVS_W-1:0] dvs_q;
	logic                      num_neg_q;
	logic                      den_neg_q;

	logic signed [15:0] res_cv_q;
	logic [11:0]        res_code_q;
	logic [11:0]        res_point_q;
	cvc_pkg::status_t   res_status_q;

	logic               out_valid_q;
	logic signed [15:0] out_cv_q;
	logic [11:0]        out_code_q;
	logic [11:0]        out_point_q;
	cvc_pkg::status_t   out_status_q;

	logic signed [17:0] zero_sum;
	logic signed [17:0] four_sum;
	logic [11:0]        zero_new;
	logic [11:0]        four_new;
	logic signed [23:0] num_full;
	logic [23:0]        num_mag;
	logic [10:0]        den_mag;
	logic signed [18:0] code_full;
	logic [11:0]        span;
	logic [cvc_pkg::DVS_W:0] trial;
	logic               trial_ge;
	logic [cvc_pkg::DVD_W-1:0] quo;
	logic               quo_neg;

	always_comb begin
		zero_sum = $signed({6'd0, out_zero_q[ch_q]}) + 18'(delta_q);
		four_sum = $signed({6'd0, out_four_q[ch_q]}) + 18'(delta_q);
		if (zero_sum < 18'sd0) begin
			zero_new = '0;
		end else if (zero_sum > $signed({6'd0, out_four_q[ch_q]})) begin
			zero_new = out_four_q[ch_q];
		end else begin
			zero_new = zero_sum[11:0];
		end
		if (four_sum < $signed({6'd0, out_zero_q[ch_q]})) begin
			four_new = out_zero_q[ch_q];
		end else if (four_sum > $signed({6'd0, cvc_pkg::CODE_MAX})) begin
			four_new = cvc_pkg::CODE_MAX;
		end else begin
			four_new = four_sum[11:0];
		end

		num_full  = ndiff_q * cvc_pkg::SPAN_MV;
		num_mag   = num_full[23] ? 24'(-num_full) : 24'(num_full);
		den_mag   = den_q[10] ? 11'(-den_q) : 11'(den_q);
		code_full = 19'($signed(prod_q[33:16])) + $signed({7'd0, out_zero_q[ch_q]});
		span      = out_four_q[ch_q] - out_zero_q[ch_q];

		trial    = {rem_q, dvd_q[cvc_pkg::DVD_W-1]};
		trial_ge = (trial >= {1'b0, dvs_q});
		quo      = dvd_q;
		quo_neg  = num_neg_q ^ den_neg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_zero_q[0]  <= cvc_pkg::IN_ZERO_RST0;
			in_four_q[0]  <= cvc_pkg::IN_FOUR_RST0;
			in_zero_q[1]  <= cvc_pkg::IN_ZERO_RST1;
			in_four_q[1]  <= cvc_pkg::IN_FOUR_RST1;
			out_zero_q[0] <= cvc_pkg::OUT_ZERO_RST0;
			out_zero_q[1] <= cvc_pkg::OUT_ZERO_RST1;
			out_four_q[0] <= cvc_pkg::OUT_FOUR_RST0;
			out_four_q[1] <= cvc_pkg::OUT_FOUR_RST1;
			slope_q[0]    <= cvc_pkg::SLOPE_RST0;
			slope_q[1]    <= cvc_pkg::SLOPE_RST1;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cvc_pkg::CFG_CH1_IN_ZERO: in_zero_q[0] <= cfg_data;
					cvc_pkg::CFG_CH1_IN_FOUR: in_four_q[0] <= cfg_data;
					cvc_pkg::CFG_CH2_IN_ZERO: in_zero_q[1] <= cfg_data;
					cvc_pkg::CFG_CH2_IN_FOUR: in_four_q[1] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.prep) begin
				if (op_q == cvc_pkg::OP_TRIM_ZERO) out_zero_q[ch_q] <= zero_new;
				if (op_q == cvc_pkg::OP_TRIM_FOUR) out_four_q[ch_q] <= four_new;
			end
			if (cmd.fin && op_q != cvc_pkg::OP_CONV_IN) begin
				slope_q[ch_q] <= quo[16:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q    <= op;
			ch_q    <= channel;
			raw_q   <= raw_sample;
			mv_q    <= millivolts;
			delta_q <= trim_delta;
		end

		if (cmd.prep) begin
			ndiff_q <= $signed({1'b0, in_zero_q[ch_q]}) - $signed({1'b0, raw_q});
			den_q   <= $signed({1'b0, in_zero_q[ch_q]}) - $signed({1'b0, in_four_q[ch_q]});
			prod_q  <= $signed({1'b0, slope_q[ch_q]}) * mv_q;
			point_q <= (op_q == cvc_pkg::OP_TRIM_ZERO) ? zero_new : four_new;
		end

		if (cmd.load) begin
			rem_q       <= '0;
			res_cv_q    <= '0;
			res_code_q  <= '0;
			res_point_q <= '0;
			case (op_q)
				cvc_pkg::OP_CONV_IN: begin
					dvd_q     <= num_mag[cvc_pkg::DVD_W-1:0];
					dvs_q     <= den_mag[cvc_pkg::DVS_W-1:0];
					num_neg_q <= num_full[23];
					den_neg_q <= den_q[10];
					// A zero span saturates toward the sign of the numerator.
					res_status_q <= cvc_pkg::ST_DIV_ZERO;
					if (ndiff_q > 11'sd0) begin
						res_cv_q <= 16'sd32767;
					end else if (ndiff_q < 11'sd0) begin
						res_cv_q <= -16'sd32768;
					end
				end
				cvc_pkg::OP_CONV_OUT: begin
					if (code_full < 19'sd0) begin
						res_status_q <= cvc_pkg::ST_SAT;
					end else if (code_full > $signed({7'd0, cvc_pkg::CODE_MAX})) begin
						res_code_q   <= cvc_pkg::CODE_MAX;
						res_status_q <= cvc_pkg::ST_SAT;
					end else begin
						res_code_q   <= code_full[11:0];
						res_status_q <= cvc_pkg::ST_OK;
					end
				end
				default: begin
					dvd_q     <= {span, cvc_pkg::SLOPE_SHIFT'(0)};
					dvs_q     <= cvc_pkg::SLOPE_DVS;
					num_neg_q <= 1'b0;
					den_neg_q <= 1'b0;
				end
			endcase
		end

		// Restoring division, one quotient bit per step, shifted into the dividend.
		if (cmd.div_step) begin
			rem_q <= trial_ge ? cvc_pkg::DVS_W'(trial - {1'b0, dvs_q})
			                  : trial[cvc_pkg::DVS_W-1:0];
			dvd_q <= {dvd_q[cvc_pkg::DVD_W-2:0], trial_ge};
		end

		if (cmd.fin) begin
			res_code_q <= '0;
			if (op_q == cvc_pkg::OP_CONV_IN) begin
				res_point_q <= '0;
				if (quo_neg) begin
					if (quo > cvc_pkg::DVD_W'(32768)) begin
						res_cv_q     <= -16'sd32768;
						res_status_q <= cvc_pkg::ST_SAT;
					end else begin
						res_cv_q     <= 16'(16'd0 - quo[15:0]);
						res_status_q <= cvc_pkg::ST_OK;
					end
				end else if (quo > cvc_pkg::DVD_W'(32767)) begin
					res_cv_q     <= 16'sd32767;
					res_status_q <= cvc_pkg::ST_SAT;
				end else begin
					res_cv_q     <= $signed(quo[15:0]);
					res_status_q <= cvc_pkg::ST_OK;
				end
			end else begin
				res_cv_q     <= '0;
				res_point_q  <= point_q;
				res_status_q <= cvc_pkg::ST_OK;
			end
		end

		if (cmd.out_load) begin
			out_cv_q     <= res_cv_q;
			out_code_q   <= res_code_q;
			out_point_q  <= res_point_q;
			out_status_q <= res_status_q;
		end
	end

	always_comb begin
		stat.op       = op_q;
		stat.den_zero = (den_q == 11'sd0);
		stat.out_free = !out_valid_q || rsp.ready;
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.cv_in_mv    = out_cv_q;
	assign rsp.dac_code    = out_code_q;
	assign rsp.point_value = out_point_q;
	assign rsp.status      = out_status_q;

endmodule

@@ hdl/cv_two_point_calibration_top.sv @@
// Top level of the two-channel control-voltage calibrator.
// Input conversion and trims run through the 23-step restoring divider; output
// conversion and a zero input span skip it.
// One request is in work at a time: a new request is taken in the cycle after the
// result enters the output register.
// Reset clears the controller and the output valid and restores all calibration points.
module cv_two_point_calibration_top (
	input  logic      clk,
	input  logic      arst_n,
	cvc_req_if.sink   req,
	cvc_rsp_if.source rsp,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	cvc_pkg::ctrl_cmd_t cmd;
	cvc_pkg::dp_stat_t  stat;
	logic               req_ready;

	cvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	assign req.ready = req_ready;

	cvc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (req.op),
		.channel    (req.channel),
		.raw_sample (req.raw_sample),
		.millivolts (req.millivolts),
		.trim_delta (req.trim_delta),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rsp        (rsp)
	);

endmodule

@@ sim/cv_two_point_calibration_top_tb.sv @@
// Self-checking testbench of the two-channel control-voltage calibrator.
`timescale 1ns / 100ps

module cv_two_point_calibration_top_tb;
	import cvc_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RST_CYCLES  = 6;
	localparam int MV_SPAN     = 4000;
	localparam int DAC_TOP     = 4095;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		op_t                op;
		logic               channel;
		logic [9:0]         raw;
		logic signed [15:0] mv;
		logic signed [15:0] delta;
	} cal_req_t;

	typedef struct packed {
		logic signed [15:0] cv;
		logic [11:0]        dac;
		logic [11:0]        point;
		status_t            status;
	} cal_rsp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	logic     req_valid_q = 1'b0;
	cal_req_t req_drv = '0;
	logic     rsp_ready_q = 1'b0;

	cvc_req_if req_ch ();
	cvc_rsp_if rsp_ch ();

	assign req_ch.valid      = req_valid_q;
	assign req_ch.op         = req_drv.op;
	assign req_ch.channel    = req_drv.channel;
	assign req_ch.raw_sample = req_drv.raw;
	assign req_ch.millivolts = req_drv.mv;
	assign req_ch.trim_delta = req_drv.delta;
	assign rsp_ch.ready      = rsp_ready_q;

	cv_two_point_calibration_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Calibration state as the block should hold it.
	logic [9:0] adc_zero [2];
	logic [9:0] adc_four [2];
	int         dac_zero [2];
	int         dac_four [2];
	int         dac_slope [2];

	cal_req_t cal_pending [$];
	cal_rsp_t cal_expected [$];
	cal_req_t req_item;

	int   src_gap = 0;
	int   sink_gap = 0;
	int   idle_pct = 0;
	int   mismatches = 0;
	logic timed_out = 1'b0;

	// The trim clamps keep four >= zero, so truncation equals the floor here.
	function automatic int slope_of(input int zero, input int four);
		return ((four - zero) * 65536) / MV_SPAN;
	endfunction

	function automatic cal_rsp_t calibrate(input cal_req_t r);
		cal_rsp_t res;
		int       ch;
		int       num;
		int       den;
		int       q;
		int       t;
		longint   prod;
		longint   code;
		ch = int'(r.channel);
		res = '0;
		res.status = ST_OK;
		case (r.op)
			OP_CONV_IN: begin
				num = (int'(adc_zero[ch]) - int'(r.raw)) * MV_SPAN;
				den = int'(adc_zero[ch]) - int'(adc_four[ch]);
				if (den == 0) begin
					res.status = ST_DIV_ZERO;
					res.cv = (num > 0) ? 16'sd32767 : ((num < 0) ? -16'sd32768 : 16'sd0);
				end else begin
					q = num / den;
					if (q > 32767) begin
						q = 32767;
						res.status = ST_SAT;
					end else if (q < -32768) begin
						q = -32768;
						res.status = ST_SAT;
					end
					res.cv = 16'(q);
				end
			end
			OP_CONV_OUT: begin
				// The arithmetic shift of the signed product is the floor division.
				prod = longint'(dac_slope[ch]) * longint'(r.mv);
				code = (prod >>> 16) + longint'(dac_zero[ch]);
				if (code < 0) begin
					code = 0;
					res.status = ST_SAT;
				end else if (code > DAC_TOP) begin
					code = DAC_TOP;
					res.status = ST_SAT;
				end
				res.dac = 12'(code);
			end
			OP_TRIM_ZERO: begin
				t = dac_zero[ch] + int'(r.delta);
				if (t < 0) t = 0;
				if (t > dac_four[ch]) t = dac_four[ch];
				dac_zero[ch] = t;
				dac_slope[ch] = slope_of(dac_zero[ch], dac_four[ch]);
				res.point = 12'(t);
			end
			default: begin
				t = dac_four[ch] + int'(r.delta);
				if (t < dac_zero[ch]) t = dac_zero[ch];
				if (t > DAC_TOP) t = DAC_TOP;
				dac_four[ch] = t;
				dac_slope[ch] = slope_of(dac_zero[ch], dac_four[ch]);
				res.point = 12'(t);
			end
		endcase
		return res;
	endfunction

	function automatic cal_req_t mk(input op_t op, input logic ch, input int raw,
		input int mv, input int delta);
		cal_req_t r;
		r.op = op;
		r.channel = ch;
		r.raw = 10'(raw);
		r.mv = 16'(mv);
		r.delta = 16'(delta);
		return r;
	endfunction

	function automatic cal_req_t rand_item();
		cal_req_t r;
		int       pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) r.op = OP_CONV_IN;
		else if (pick < 7) r.op = OP_CONV_OUT;
		else if (pick < 9) r.op = OP_TRIM_ZERO;
		else r.op = OP_TRIM_FOUR;
		r.channel = 1'($urandom_range(0, 1));
		r.raw = 10'($urandom);
		if ($urandom_range(0, 3) == 0) r.mv = 16'($urandom);
		else r.mv = 16'(int'($urandom_range(0, 9000)) - 2000);
		case ($urandom_range(0, 3))
			0, 1: r.delta = 16'(int'($urandom_range(0, 600)) - 300);
			2: r.delta = 16'($urandom);
			default: r.delta = ($urandom_range(0, 1) != 0) ? 16'sd4095 : -16'sd4095;
		endcase
		return r;
	endfunction

	task automatic log_fault(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [9:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_CH1_IN_ZERO: adc_zero[0] = val;
			CFG_CH1_IN_FOUR: adc_four[0] = val;
			CFG_CH2_IN_ZERO: adc_zero[1] = val;
			default: adc_four[1] = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_adc_points(input int z1, input int f1, input int z2, input int f2);
		cfg_write(CFG_CH1_IN_ZERO, 10'(z1));
		cfg_write(CFG_CH1_IN_FOUR, 10'(f1));
		cfg_write(CFG_CH2_IN_ZERO, 10'(z2));
		cfg_write(CFG_CH2_IN_FOUR, 10'(f2));
	endtask

	// Equal points, a span of a few codes, or any pair, per channel.
	task automatic set_random_adc_points();
		int z [2];
		int f [2];
		for (int c = 0; c < 2; c++) begin
			z[c] = $urandom_range(0, 1023);
			case ($urandom_range(0, 4))
				0: f[c] = z[c];
				1: f[c] = (z[c] >= 3) ? z[c] - int'($urandom_range(1, 3))
					: z[c] + int'($urandom_range(1, 3));
				default: f[c] = $urandom_range(0, 1023);
			endcase
		end
		set_adc_points(z[0], f[0], z[1], f[1]);
	endtask

	task automatic send_random(input int n);
		repeat (n) cal_pending.push_back(rand_item());
	endtask

	// Checked at the falling edge, once the driver and monitor have settled.
	task automatic drain();
		while (!(cal_pending.size() == 0 && !req_valid_q && cal_expected.size() == 0))
			@(negedge clk);
	endtask

	// Request driver: holds each request until it is taken, then maybe idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
			src_gap = 0;
		end else begin
			if (req_valid_q && req_ch.ready) begin
				cal_expected.push_back(calibrate(req_item));
				if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
					src_gap = $urandom_range(1, 19);
			end
			if (!req_valid_q || req_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					req_valid_q <= 1'b0;
				end else if (cal_pending.size() > 0) begin
					req_item = cal_pending.pop_front();
					req_drv <= req_item;
					req_valid_q <= 1'b1;
				end else begin
					req_valid_q <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready_q <= 1'b0;
			sink_gap = 0;
		end else begin
			if (rsp_ch.valid && rsp_ready_q) begin
				if (cal_expected.size() == 0) begin
					log_fault($sformatf("unexpected result: cv %0d dac %0d point %0d status %0d",
						rsp_ch.cv_in_mv, rsp_ch.dac_code, rsp_ch.point_value, rsp_ch.status));
				end else if (rsp_ch.cv_in_mv !== cal_expected[0].cv
					|| rsp_ch.dac_code !== cal_expected[0].dac
					|| rsp_ch.point_value !== cal_expected[0].point
					|| rsp_ch.status !== cal_expected[0].status) begin
					log_fault($sformatf({"mismatch: expected cv %0d dac %0d point %0d status %0d,",
						" got cv %0d dac %0d point %0d status %0d"},
						cal_expected[0].cv, cal_expected[0].dac, cal_expected[0].point,
						cal_expected[0].status, rsp_ch.cv_in_mv, rsp_ch.dac_code,
						rsp_ch.point_value, rsp_ch.status));
				end
				if (cal_expected.size() != 0) void'(cal_expected.pop_front());
			end
			if (sink_gap > 0) begin
				sink_gap--;
				rsp_ready_q <= 1'b0;
			end else begin
				rsp_ready_q <= 1'b1;
				if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
					sink_gap = $urandom_range(1, 19);
			end
		end
	end

	initial begin
		int quiet;
		adc_zero[0] = 10'd571;
		adc_four[0] = 10'd269;
		adc_zero[1] = 10'd573;
		adc_four[1] = 10'd270;
		dac_zero[0] = 1335;
		dac_four[0] = 2659;
		dac_zero[1] = 1328;
		dac_four[1] = 2653;
		dac_slope[0] = slope_of(dac_zero[0], dac_four[0]);
		dac_slope[1] = slope_of(dac_zero[1], dac_four[1]);
		fork
			begin
				repeat (RST_CYCLES) @(posedge clk);
				arst_n <= 1'b1;

				// Reset calibration: conversion extremes, DAC saturation and trim clamps.
				idle_pct = 20;
				cal_pending.push_back(mk(OP_CONV_IN, 1'b0, 0, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b0, 1023, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b0, 571, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b1, 270, 0, 0));
				cal_pending.push_back(mk(OP_CONV_OUT, 1'b0, 0, 0, 0));
				cal_pending.push_back(mk(OP_CONV_OUT, 1'b0, 0, 4000, 0));
				cal_pending.push_back(mk(OP_CONV_OUT, 1'b0, 0, 32767, 0));
				cal_pending.push_back(mk(OP_CONV_OUT, 1'b0, 0, -32768, 0));
				cal_pending.push_back(mk(OP_CONV_OUT, 1'b1, 0, -1, 0));
				cal_pending.push_back(mk(OP_TRIM_ZERO, 1'b0, 0, 0, 32767));
				cal_pending.push_back(mk(OP_TRIM_ZERO, 1'b0, 0, 0, -32768));
				cal_pending.push_back(mk(OP_TRIM_FOUR, 1'b0, 0, 0, -32768));
				cal_pending.push_back(mk(OP_CONV_OUT, 1'b0, 0, 1000, 0));
				cal_pending.push_back(mk(OP_TRIM_FOUR, 1'b0, 0, 0, 32767));
				cal_pending.push_back(mk(OP_TRIM_ZERO, 1'b1, 0, 0, 0));
				cal_pending.push_back(mk(OP_TRIM_FOUR, 1'b1, 0, 0, -1));
				cal_pending.push_back(mk(OP_CONV_OUT, 1'b1, 0, 4000, 0));
				drain();

				// Full-scale spans of both signs.
				set_adc_points(1023, 0, 0, 1023);
				cal_pending.push_back(mk(OP_CONV_IN, 1'b0, 0, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b0, 1023, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b1, 1023, 0, 0));
				send_random(80);
				drain();

				// Equal input points on channel 0, a one-code span on channel 1.
				idle_pct = 0;
				set_adc_points(500, 500, 1000, 999);
				cal_pending.push_back(mk(OP_CONV_IN, 1'b0, 500, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b0, 100, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b0, 900, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b1, 0, 0, 0));
				cal_pending.push_back(mk(OP_CONV_IN, 1'b1, 1023, 0, 0));
				send_random(80);
				drain();

				repeat (3) begin
					idle_pct = $urandom_range(10, 40);
					set_random_adc_points();
					send_random(80);
					drain();
				end

				// Last stretch runs at full rate on both sides.
				idle_pct = 0;
				set_random_adc_points();
				send_random(60);
				drain();
				repeat (TAIL_CYCLES) @(posedge clk);
			end
			begin
				quiet = 0;
				while (quiet < STALL_LIMIT) begin
					@(posedge clk);
					if ((req_valid_q && req_ch.ready) || (rsp_ch.valid && rsp_ready_q))
						quiet = 0;
					else
						quiet++;
				end
				timed_out = 1'b1;
			end
		join_any
		if (!timed_out && mismatches == 0 && cal_expected.size() == 0)
			$display("[cv_two_point_calibration_top] OK");
		else
			$display("[cv_two_point_calibration_top] ERROR");
		$finish;
	end

endmodule
